[rtl/core/ordered_array_insert_remove_assert.svh]
// Assertion macros used by oair_checker.
`ifndef ORDERED_ARRAY_INSERT_REMOVE_ASSERT_SVH
`define ORDERED_ARRAY_INSERT_REMOVE_ASSERT_SVH

// Same-cycle implication, sampled on i_clk and disabled during reset.
`define OAIR_ASSERT_IMP(name, cond, prop) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (prop)) \
        else $error("ordered array assertion failed");

// Next-cycle implication, sampled on i_clk and disabled during reset.
`define OAIR_ASSERT_NXT(name, cond, prop) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (prop)) \
        else $error("ordered array assertion failed");

`endif

[rtl/core/oair_pkg.sv]
package oair_pkg;

    localparam int DEPTH       = 64;
    localparam int ENTRY_BITS  = 32;

    localparam int OP_W        = 3;
    localparam int POS_W       = 7;
    localparam int VAL_W       = 32;
    localparam int LIMIT_W     = 7;
    localparam int COUNT_OUT_W = 7;
    localparam int STATUS_W    = 2;
    localparam int WIDE_W      = 64;

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(64);

    typedef enum logic [OP_W-1:0] {
        OP_PUSH      = 3'd0,
        OP_POP       = 3'd1,
        OP_INSERT    = 3'd2,
        OP_REMOVE    = 3'd3,
        OP_READ      = 3'd4,
        OP_READ_BACK = 3'd5,
        OP_CLEAR     = 3'd6,
        OP_NONE      = 3'd7
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_SHIFT_UP,
        S_SHIFT_DN,
        S_DRAIN_UP,
        S_DRAIN_DN,
        S_WR_VAL,
        S_RD_WAIT,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic load_req;
        logic push_wr;
        logic start_ins;
        logic start_rem;
        logic step_ins;
        logic step_rem;
        logic val_wr;
        logic rd_pos;
        logic rd_back;
        logic cap_rd;
        logic finish;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic ok;
        logic no_move;
        logic last_step;
        logic out_free;
    } t_sts;

endpackage

[rtl/core/oair_controller.sv]
module oair_controller (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  oair_pkg::t_sts  i_sts,
    output logic            o_in_stall,
    output oair_pkg::t_cmd  o_cmd
);

    oair_pkg::t_state r_state;
    oair_pkg::t_state n_state;
    logic             accept;

    assign accept = i_in_valid && (r_state == oair_pkg::S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= oair_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            oair_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = oair_pkg::S_EXEC;
                end
            end
            oair_pkg::S_EXEC: begin
                n_state = oair_pkg::S_FINISH;
                if (i_sts.ok) begin
                    case (i_sts.op)
                        oair_pkg::OP_INSERT: begin
                            n_state = i_sts.no_move ? oair_pkg::S_WR_VAL : oair_pkg::S_SHIFT_UP;
                        end
                        oair_pkg::OP_REMOVE: begin
                            n_state = i_sts.no_move ? oair_pkg::S_FINISH : oair_pkg::S_SHIFT_DN;
                        end
                        oair_pkg::OP_READ, oair_pkg::OP_READ_BACK: begin
                            n_state = oair_pkg::S_RD_WAIT;
                        end
                        default: begin
                            n_state = oair_pkg::S_FINISH;
                        end
                    endcase
                end
            end
            oair_pkg::S_SHIFT_UP: begin
                if (i_sts.last_step) begin
                    n_state = oair_pkg::S_DRAIN_UP;
                end
            end
            oair_pkg::S_SHIFT_DN: begin
                if (i_sts.last_step) begin
                    n_state = oair_pkg::S_DRAIN_DN;
                end
            end
            oair_pkg::S_DRAIN_UP: begin
                n_state = oair_pkg::S_WR_VAL;
            end
            oair_pkg::S_DRAIN_DN: begin
                n_state = oair_pkg::S_FINISH;
            end
            oair_pkg::S_WR_VAL: begin
                n_state = oair_pkg::S_FINISH;
            end
            oair_pkg::S_RD_WAIT: begin
                n_state = oair_pkg::S_FINISH;
            end
            oair_pkg::S_FINISH: begin
                if (i_sts.out_free) begin
                    n_state = oair_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = oair_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = (r_state != oair_pkg::S_IDLE);
        unique case (r_state)
            oair_pkg::S_IDLE: begin
                o_cmd.load_req = accept;
            end
            oair_pkg::S_EXEC: begin
                if (i_sts.ok) begin
                    case (i_sts.op)
                        oair_pkg::OP_PUSH:      o_cmd.push_wr   = 1'b1;
                        oair_pkg::OP_INSERT:    o_cmd.start_ins = 1'b1;
                        oair_pkg::OP_REMOVE:    o_cmd.start_rem = 1'b1;
                        oair_pkg::OP_READ:      o_cmd.rd_pos    = 1'b1;
                        oair_pkg::OP_READ_BACK: o_cmd.rd_back   = 1'b1;
                        default: begin
                        end
                    endcase
                end
            end
            oair_pkg::S_SHIFT_UP: begin
                o_cmd.step_ins = 1'b1;
            end
            oair_pkg::S_SHIFT_DN: begin
                o_cmd.step_rem = 1'b1;
            end
            oair_pkg::S_WR_VAL: begin
                o_cmd.val_wr = 1'b1;
            end
            oair_pkg::S_RD_WAIT: begin
                o_cmd.cap_rd = 1'b1;
            end
            oair_pkg::S_FINISH: begin
                o_cmd.finish = i_sts.out_free;
            end
            default: begin
            end
        endcase
    end

endmodule

[rtl/core/oair_datapath.sv]
module oair_datapath (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [oair_pkg::LIMIT_W-1:0]       i_cfg_wdata,
    input  logic [oair_pkg::OP_W-1:0]          i_op,
    input  logic [oair_pkg::POS_W-1:0]         i_position,
    input  logic [oair_pkg::VAL_W-1:0]         i_entry_value,
    input  logic                               i_out_stall,
    input  oair_pkg::t_cmd                     i_cmd,
    output oair_pkg::t_sts                     o_sts,
    output logic                               o_out_valid,
    output logic [oair_pkg::VAL_W-1:0]         o_read_value,
    output logic [oair_pkg::COUNT_OUT_W-1:0]   o_entry_count,
    output logic [oair_pkg::STATUS_W-1:0]      o_status
);

    logic [oair_pkg::ENTRY_BITS-1:0] r_mem [oair_pkg::DEPTH];
    logic [oair_pkg::ENTRY_BITS-1:0] r_rdata;

    oair_pkg::t_op                   r_op;
    logic [oair_pkg::CMPW-1:0]       r_pos;
    logic [oair_pkg::ENTRY_BITS-1:0] r_val;
    logic [oair_pkg::ENTRY_BITS-1:0] r_res;
    logic [oair_pkg::CW-1:0]         r_count;
    logic [oair_pkg::CW-1:0]         n_count;
    logic [oair_pkg::LIMIT_W-1:0]    r_limit;
    logic [oair_pkg::AW-1:0]         r_ptr;
    logic                            r_wv;
    logic [oair_pkg::AW-1:0]         r_wa;

    logic                               r_out_valid;
    logic [oair_pkg::VAL_W-1:0]         r_out_data;
    logic [oair_pkg::COUNT_OUT_W-1:0]   r_out_count;
    oair_pkg::t_status                  r_out_status;

    logic [oair_pkg::WIDE_W-1:0]     wide_in;
    logic [oair_pkg::WIDE_W-1:0]     wide_res;
    logic [oair_pkg::CMPW-1:0]       cnt_x;
    logic [oair_pkg::CMPW-1:0]       lim_x;
    logic [oair_pkg::CMPW-1:0]       ptr_x;
    logic [oair_pkg::CW-1:0]         back_idx;
    logic                            full;
    logic                            empty;
    oair_pkg::t_status               status;
    logic                            no_move;
    logic                            last_step;
    logic                            out_free;

    logic                            we;
    logic [oair_pkg::AW-1:0]         wa;
    logic [oair_pkg::ENTRY_BITS-1:0] wd;
    logic                            re;
    logic [oair_pkg::AW-1:0]         ra;

    assign wide_in  = oair_pkg::WIDE_W'(i_entry_value);
    assign wide_res = oair_pkg::WIDE_W'(r_res);
    assign cnt_x    = oair_pkg::CMPW'(r_count);
    assign lim_x    = (oair_pkg::CMPW'(r_limit) > oair_pkg::CMPW'(oair_pkg::DEPTH))
                    ? oair_pkg::CMPW'(oair_pkg::DEPTH) : oair_pkg::CMPW'(r_limit);
    assign ptr_x    = oair_pkg::CMPW'(r_ptr);
    assign back_idx = r_count - oair_pkg::CW'(1);
    assign full     = (cnt_x >= lim_x);
    assign empty    = (r_count == '0);
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        status = oair_pkg::ST_OK;
        case (r_op)
            oair_pkg::OP_PUSH: begin
                if (full) status = oair_pkg::ST_FULL;
            end
            oair_pkg::OP_INSERT: begin
                if (full) status = oair_pkg::ST_FULL;
                else if (r_pos > cnt_x) status = oair_pkg::ST_RANGE;
            end
            oair_pkg::OP_POP, oair_pkg::OP_READ_BACK: begin
                if (empty) status = oair_pkg::ST_EMPTY;
            end
            oair_pkg::OP_REMOVE, oair_pkg::OP_READ: begin
                if (empty) status = oair_pkg::ST_EMPTY;
                else if (r_pos >= cnt_x) status = oair_pkg::ST_RANGE;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        no_move   = 1'b0;
        last_step = 1'b0;
        case (r_op)
            oair_pkg::OP_INSERT: begin
                no_move   = (r_pos == cnt_x);
                last_step = (ptr_x == r_pos + oair_pkg::CMPW'(1));
            end
            oair_pkg::OP_REMOVE: begin
                no_move   = (r_pos + oair_pkg::CMPW'(1) == cnt_x);
                last_step = (ptr_x + oair_pkg::CMPW'(1) == cnt_x);
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_count = r_count;
        if (status == oair_pkg::ST_OK) begin
            case (r_op)
                oair_pkg::OP_PUSH, oair_pkg::OP_INSERT: n_count = r_count + oair_pkg::CW'(1);
                oair_pkg::OP_POP, oair_pkg::OP_REMOVE:  n_count = r_count - oair_pkg::CW'(1);
                oair_pkg::OP_CLEAR:                     n_count = '0;
                default:                                n_count = r_count;
            endcase
        end
    end

    always_comb begin
        we = 1'b1;
        wa = r_wa;
        wd = r_rdata;
        if (!r_wv) begin
            wd = r_val;
            if (i_cmd.push_wr) begin
                wa = r_count[oair_pkg::AW-1:0];
            end else if (i_cmd.val_wr) begin
                wa = r_pos[oair_pkg::AW-1:0];
            end else begin
                we = 1'b0;
            end
        end
    end

    always_comb begin
        re = 1'b1;
        ra = r_ptr;
        if (i_cmd.step_ins) begin
            ra = r_ptr - oair_pkg::AW'(1);
        end else if (i_cmd.step_rem) begin
            ra = r_ptr;
        end else if (i_cmd.rd_pos) begin
            ra = r_pos[oair_pkg::AW-1:0];
        end else if (i_cmd.rd_back) begin
            ra = back_idx[oair_pkg::AW-1:0];
        end else begin
            re = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[wa] <= wd;
        end
        if (re) begin
            r_rdata <= r_mem[ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_op  <= oair_pkg::t_op'(i_op);
            r_pos <= oair_pkg::CMPW'(i_position);
            r_val <= wide_in[oair_pkg::ENTRY_BITS-1:0];
            r_res <= '0;
        end else if (i_cmd.cap_rd) begin
            r_res <= r_rdata;
        end
        if (i_cmd.start_ins) begin
            r_ptr <= r_count[oair_pkg::AW-1:0];
        end else if (i_cmd.start_rem) begin
            r_ptr <= r_pos[oair_pkg::AW-1:0] + oair_pkg::AW'(1);
        end else if (i_cmd.step_ins) begin
            r_ptr <= r_ptr - oair_pkg::AW'(1);
        end else if (i_cmd.step_rem) begin
            r_ptr <= r_ptr + oair_pkg::AW'(1);
        end
        if (i_cmd.step_ins) begin
            r_wa <= r_ptr;
        end else if (i_cmd.step_rem) begin
            r_wa <= r_ptr - oair_pkg::AW'(1);
        end
        if (i_cmd.finish) begin
            r_out_data   <= wide_res[oair_pkg::VAL_W-1:0];
            r_out_count  <= oair_pkg::COUNT_OUT_W'(n_count);
            r_out_status <= status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_limit     <= oair_pkg::LIMIT_RESET;
            r_wv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_wv <= i_cmd.step_ins || i_cmd.step_rem;
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            if (i_cmd.finish) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.op        = r_op;
    assign o_sts.ok        = (status == oair_pkg::ST_OK);
    assign o_sts.no_move   = no_move;
    assign o_sts.last_step = last_step;
    assign o_sts.out_free  = out_free;

    assign o_out_valid   = r_out_valid;
    assign o_read_value  = r_out_data;
    assign o_entry_count = r_out_count;
    assign o_status      = r_out_status;

endmodule

[rtl/core/ordered_array_insert_remove.sv]
// Bounded ordered array of 64 entries of 32 bits, one request per transfer.
// Input channel: i_in_valid with o_in_stall carries i_op, i_position and
// i_entry_value. Output channel: o_out_valid with i_out_stall carries
// o_read_value, o_entry_count and o_status, one result per request.
// The register capacity_limit is written through i_cfg_we and i_cfg_wdata.
// One request is worked at a time; o_in_stall is high from the cycle after
// a transfer until the result is loaded into the output register.
// Each request passes EXEC and ends in FINISH. Push, pop, clear, the unused
// op, failed requests and removing the back entry go straight there; reads
// pass RD_WAIT and inserting at the back passes WR_VAL. Any other insert
// shifts entries up in SHIFT_UP, then passes DRAIN_UP and WR_VAL; any other
// remove shifts down in SHIFT_DN, then passes DRAIN_DN. The entry memory
// moves one entry per cycle. The next request is taken the cycle after the
// result is loaded, while that result may still wait in the output register.
// A stalled result holds in the output register; when a new result is ready
// and the output register is still stalled, the block waits before loading.
// Reset, synchronous and active low, empties the array, sets the limit to 64
// and drops o_out_valid; the memory contents are not cleared.
module ordered_array_insert_remove (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [oair_pkg::LIMIT_W-1:0]       i_cfg_wdata,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [oair_pkg::OP_W-1:0]          i_op,
    input  logic [oair_pkg::POS_W-1:0]         i_position,
    input  logic [oair_pkg::VAL_W-1:0]         i_entry_value,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [oair_pkg::VAL_W-1:0]         o_read_value,
    output logic [oair_pkg::COUNT_OUT_W-1:0]   o_entry_count,
    output logic [oair_pkg::STATUS_W-1:0]      o_status
);

    oair_pkg::t_cmd cmd;
    oair_pkg::t_sts sts;

    oair_controller u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    oair_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_op          (i_op),
        .i_position    (i_position),
        .i_entry_value (i_entry_value),
        .i_out_stall   (i_out_stall),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_out_valid   (o_out_valid),
        .o_read_value  (o_read_value),
        .o_entry_count (o_entry_count),
        .o_status      (o_status)
    );

endmodule

[rtl/core/oair_checker.sv]
`include "ordered_array_insert_remove_assert.svh"

module oair_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_cfg_we,
    input logic [oair_pkg::LIMIT_W-1:0]       i_cfg_wdata,
    input logic                               i_in_valid,
    input logic                               o_in_stall,
    input logic [oair_pkg::OP_W-1:0]          i_op,
    input logic [oair_pkg::POS_W-1:0]         i_position,
    input logic [oair_pkg::VAL_W-1:0]         i_entry_value,
    input logic                               o_out_valid,
    input logic                               i_out_stall,
    input logic [oair_pkg::VAL_W-1:0]         o_read_value,
    input logic [oair_pkg::COUNT_OUT_W-1:0]   o_entry_count,
    input logic [oair_pkg::STATUS_W-1:0]      o_status
);

    // A stalled result stays offered.
    `OAIR_ASSERT_NXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid)

    // Only one request is in work: a transfer closes the input side.
    `OAIR_ASSERT_NXT(a_one_in_work, i_in_valid && !o_in_stall, o_in_stall)

    // A failed request returns no data.
    `OAIR_ASSERT_IMP(a_fail_no_data, o_out_valid && (o_status != oair_pkg::ST_OK),
                     o_read_value == '0)

    // An empty report means the array holds nothing.
    `OAIR_ASSERT_IMP(a_empty_count, o_out_valid && (o_status == oair_pkg::ST_EMPTY),
                     o_entry_count == '0)

endmodule

bind ordered_array_insert_remove oair_checker u_oair_checker (.*);

[verif/ordered_array_insert_remove_checker.sv]
`timescale 1ns / 100ps

module ordered_array_insert_remove_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [oair_pkg::LIMIT_W-1:0]       i_cfg_wdata,
    input  logic                               i_in_valid,
    input  logic                               i_in_stall,
    input  logic [oair_pkg::OP_W-1:0]          i_op,
    input  logic [oair_pkg::POS_W-1:0]         i_position,
    input  logic [oair_pkg::VAL_W-1:0]         i_entry_value,
    input  logic                               i_out_valid,
    input  logic                               i_out_stall,
    input  logic [oair_pkg::VAL_W-1:0]         i_read_value,
    input  logic [oair_pkg::COUNT_OUT_W-1:0]   i_entry_count,
    input  logic [oair_pkg::STATUS_W-1:0]      i_status,
    output int                                 o_fail_count,
    output int                                 o_pending,
    output int                                 o_count_hint
);

    typedef struct packed {
        logic [oair_pkg::VAL_W-1:0]       read_value;
        logic [oair_pkg::COUNT_OUT_W-1:0] entry_count;
        oair_pkg::t_status                status;
    } t_array_result;

    logic [oair_pkg::VAL_W-1:0] mirror_entries [oair_pkg::DEPTH];
    int unsigned                mirror_count;
    int unsigned                mirror_limit;
    t_array_result              expected_results [$];
    int                         mismatch_count;

    function automatic t_array_result apply_request(oair_pkg::t_op op, int unsigned pos,
                                                    logic [oair_pkg::VAL_W-1:0] val);
        t_array_result res;
        int unsigned   lim;
        int unsigned   i;
        res.read_value = '0;
        res.status     = oair_pkg::ST_OK;
        lim = (mirror_limit > oair_pkg::DEPTH) ? oair_pkg::DEPTH : mirror_limit;
        case (op)
            oair_pkg::OP_PUSH: begin
                if (mirror_count >= lim) begin
                    res.status = oair_pkg::ST_FULL;
                end else begin
                    mirror_entries[mirror_count] = val;
                    mirror_count++;
                end
            end
            oair_pkg::OP_POP: begin
                if (mirror_count == 0) begin
                    res.status = oair_pkg::ST_EMPTY;
                end else begin
                    mirror_count--;
                end
            end
            oair_pkg::OP_INSERT: begin
                if (mirror_count >= lim) begin
                    res.status = oair_pkg::ST_FULL;
                end else if (pos > mirror_count) begin
                    res.status = oair_pkg::ST_RANGE;
                end else begin
                    for (i = mirror_count; i > pos; i--) begin
                        mirror_entries[i] = mirror_entries[i-1];
                    end
                    mirror_entries[pos] = val;
                    mirror_count++;
                end
            end
            oair_pkg::OP_REMOVE: begin
                if (mirror_count == 0) begin
                    res.status = oair_pkg::ST_EMPTY;
                end else if (pos >= mirror_count) begin
                    res.status = oair_pkg::ST_RANGE;
                end else begin
                    for (i = pos; i + 1 < mirror_count; i++) begin
                        mirror_entries[i] = mirror_entries[i+1];
                    end
                    mirror_count--;
                end
            end
            oair_pkg::OP_READ: begin
                if (mirror_count == 0) begin
                    res.status = oair_pkg::ST_EMPTY;
                end else if (pos >= mirror_count) begin
                    res.status = oair_pkg::ST_RANGE;
                end else begin
                    res.read_value = mirror_entries[pos];
                end
            end
            oair_pkg::OP_READ_BACK: begin
                if (mirror_count == 0) begin
                    res.status = oair_pkg::ST_EMPTY;
                end else begin
                    res.read_value = mirror_entries[mirror_count-1];
                end
            end
            oair_pkg::OP_CLEAR: begin
                mirror_count = 0;
            end
            default: begin
            end
        endcase
        res.entry_count = oair_pkg::COUNT_OUT_W'(mirror_count);
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_array_result want;
        if (!i_rst_n) begin
            mirror_count = 0;
            mirror_limit = oair_pkg::LIMIT_RESET;
            expected_results.delete();
        end else begin
            if (i_cfg_we) begin
                mirror_limit = i_cfg_wdata;
            end
            if (i_in_valid && !i_in_stall) begin
                expected_results.push_back(apply_request(oair_pkg::t_op'(i_op), i_position,
                                                         i_entry_value));
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: result transfer with nothing expected, actual %h %0d %0d",
                             $time, i_read_value, i_entry_count, i_status);
                end else begin
                    want = expected_results.pop_front();
                    if (i_read_value !== want.read_value) begin
                        mismatch_count++;
                        $display("%0t: read_value mismatch, expected %h, actual %h",
                                 $time, want.read_value, i_read_value);
                    end
                    if (i_entry_count !== want.entry_count) begin
                        mismatch_count++;
                        $display("%0t: entry_count mismatch, expected %0d, actual %0d",
                                 $time, want.entry_count, i_entry_count);
                    end
                    if (i_status !== want.status) begin
                        mismatch_count++;
                        $display("%0t: status mismatch, expected %0d, actual %0d",
                                 $time, want.status, i_status);
                    end
                end
            end
        end
        o_fail_count <= mismatch_count;
        o_pending    <= expected_results.size();
        o_count_hint <= mirror_count;
    end

endmodule

[verif/tb_ordered_array_insert_remove.sv]
`timescale 1ns / 100ps

module tb_ordered_array_insert_remove;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             i_cfg_we = 1'b0;
    logic [oair_pkg::LIMIT_W-1:0]     i_cfg_wdata = '0;
    logic                             i_in_valid = 1'b0;
    logic                             o_in_stall;
    logic [oair_pkg::OP_W-1:0]        i_op = '0;
    logic [oair_pkg::POS_W-1:0]       i_position = '0;
    logic [oair_pkg::VAL_W-1:0]       i_entry_value = '0;
    logic                             o_out_valid;
    logic                             i_out_stall = 1'b0;
    logic [oair_pkg::VAL_W-1:0]       o_read_value;
    logic [oair_pkg::COUNT_OUT_W-1:0] o_entry_count;
    logic [oair_pkg::STATUS_W-1:0]    o_status;

    int fail_count;
    int pending;
    int count_hint;
    int hold_off_cycles = 0;

    ordered_array_insert_remove uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_op          (i_op),
        .i_position    (i_position),
        .i_entry_value (i_entry_value),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_read_value  (o_read_value),
        .o_entry_count (o_entry_count),
        .o_status      (o_status)
    );

    ordered_array_insert_remove_checker checker_inst (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_op          (i_op),
        .i_position    (i_position),
        .i_entry_value (i_entry_value),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_read_value  (o_read_value),
        .i_entry_count (o_entry_count),
        .i_status      (o_status),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_count_hint  (count_hint)
    );

    always #1 i_clk = ~i_clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 80) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic oair_pkg::t_op pick_op(int grow_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < grow_pct) begin
            if ($urandom_range(0, 1) != 0) return oair_pkg::OP_PUSH;
            return oair_pkg::OP_INSERT;
        end
        r = $urandom_range(0, 99);
        if (r < 20) return oair_pkg::OP_POP;
        if (r < 45) return oair_pkg::OP_REMOVE;
        if (r < 75) return oair_pkg::OP_READ;
        if (r < 92) return oair_pkg::OP_READ_BACK;
        if (r < 97) return oair_pkg::OP_CLEAR;
        return oair_pkg::OP_NONE;
    endfunction

    task automatic send_request(input oair_pkg::t_op op, input int unsigned pos,
                                input logic [oair_pkg::VAL_W-1:0] val, input bit allow_gap);
        int gap;
        i_in_valid    <= 1'b1;
        i_op          <= op;
        i_position    <= oair_pkg::POS_W'(pos);
        i_entry_value <= val;
        do @(posedge i_clk); while (o_in_stall);
        gap = allow_gap ? pick_gap() : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic random_request(input int grow_pct, input bit allow_gap);
        int unsigned                pos;
        logic [oair_pkg::VAL_W-1:0] val;
        int                         r;
        r = $urandom_range(0, 99);
        if (r < 75) pos = $urandom_range(0, count_hint);
        else if (r < 90) pos = count_hint + $urandom_range(0, 2);
        else pos = $urandom_range(0, 127);
        r = $urandom_range(0, 99);
        if (r < 10) val = '0;
        else if (r < 20) val = '1;
        else val = $urandom;
        send_request(pick_op(grow_pct), pos, val, allow_gap);
    endtask

    task automatic random_phase(input int n_items, input int grow_pct);
        for (int k = 0; k < n_items; k++) begin
            random_request(grow_pct, 1'b1);
        end
    endtask

    task automatic wait_drained(input int settle);
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [oair_pkg::LIMIT_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    initial begin : out_side
        int len;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_off_cycles > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold_off_cycles) @(posedge i_clk);
                hold_off_cycles = 0;
            end else begin
                i_out_stall <= 1'b0;
                repeat ($urandom_range(1, 24)) @(posedge i_clk);
                len = pick_gap();
                if (len > 0) begin
                    i_out_stall <= 1'b1;
                    repeat (len) @(posedge i_clk);
                end
            end
        end
    end

    initial begin : in_side
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_request(oair_pkg::OP_READ_BACK, 0, '0, 1'b1);
        send_request(oair_pkg::OP_POP, 0, '0, 1'b1);
        send_request(oair_pkg::OP_REMOVE, 0, '0, 1'b1);
        send_request(oair_pkg::OP_READ, 127, '0, 1'b1);
        send_request(oair_pkg::OP_PUSH, 0, '0, 1'b1);
        send_request(oair_pkg::OP_PUSH, 0, '1, 1'b1);
        send_request(oair_pkg::OP_INSERT, 0, 32'hA5A5_A5A5, 1'b1);
        send_request(oair_pkg::OP_INSERT, 3, 32'h5A5A_5A5A, 1'b1);
        send_request(oair_pkg::OP_INSERT, 5, 32'h1234_5678, 1'b1);
        send_request(oair_pkg::OP_INSERT, 127, '1, 1'b1);
        send_request(oair_pkg::OP_READ, 0, '0, 1'b1);
        send_request(oair_pkg::OP_READ, 3, '0, 1'b1);
        send_request(oair_pkg::OP_READ, 4, '0, 1'b1);
        send_request(oair_pkg::OP_REMOVE, 1, '0, 1'b1);
        send_request(oair_pkg::OP_REMOVE, 3, '0, 1'b1);
        send_request(oair_pkg::OP_REMOVE, 2, '0, 1'b1);
        send_request(oair_pkg::OP_READ_BACK, 0, '0, 1'b1);
        send_request(oair_pkg::OP_NONE, 127, '1, 1'b1);
        send_request(oair_pkg::OP_CLEAR, 0, '0, 1'b1);
        send_request(oair_pkg::OP_READ_BACK, 0, '0, 1'b1);
        wait_drained(4);

        write_limit(oair_pkg::LIMIT_W'(2));
        send_request(oair_pkg::OP_PUSH, 0, 32'hDEAD_BEEF, 1'b1);
        send_request(oair_pkg::OP_PUSH, 0, 32'h0BAD_F00D, 1'b1);
        send_request(oair_pkg::OP_INSERT, 9, 32'hFFFF_0000, 1'b1);
        wait_drained(4);

        write_limit(oair_pkg::LIMIT_W'(1));
        send_request(oair_pkg::OP_READ, 1, '0, 1'b1);
        send_request(oair_pkg::OP_PUSH, 0, 32'h0000_FFFF, 1'b1);
        send_request(oair_pkg::OP_POP, 0, '0, 1'b1);
        send_request(oair_pkg::OP_PUSH, 0, 32'h0000_FFFF, 1'b1);
        wait_drained(4);

        write_limit(oair_pkg::LIMIT_W'(0));
        send_request(oair_pkg::OP_PUSH, 0, '1, 1'b1);
        send_request(oair_pkg::OP_INSERT, 0, '1, 1'b1);
        wait_drained(4);

        write_limit(oair_pkg::LIMIT_W'(127));
        random_phase(90, 75);
        wait_drained(4);

        write_limit(oair_pkg::LIMIT_W'(1));
        random_phase(40, 50);
        wait_drained(4);

        write_limit(oair_pkg::LIMIT_W'(64));
        random_phase(35, 55);
        hold_off_cycles = 400;
        while (hold_off_cycles != 0) random_request(55, 1'b0);
        random_phase(35, 55);
        wait_drained(4);

        write_limit(oair_pkg::LIMIT_W'(5));
        random_phase(50, 50);
        wait_drained(4);

        write_limit(oair_pkg::LIMIT_W'(0));
        random_phase(20, 50);
        wait_drained(4);

        write_limit(oair_pkg::LIMIT_W'(100));
        random_phase(80, 60);
        wait_drained(4);

        write_limit(oair_pkg::LIMIT_W'(33));
        random_phase(80, 50);
        wait_drained(4);

        write_limit(oair_pkg::LIMIT_W'(64));
        random_phase(70, 40);
        wait_drained(70);

        if (fail_count == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin : watchdog
        #1_500_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
